@@ src/linear_adsr_envelope_top_defines.svh @@
// assertion macros for the linear adsr envelope block
// used by the top level, expects clk_i and rst_ni in scope
`ifndef LINEAR_ADSR_ENVELOPE_TOP_DEFINES_SVH
`define LINEAR_ADSR_ENVELOPE_TOP_DEFINES_SVH

// same-cycle implication
`define LADSR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LADSR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/ladsr_pkg.sv @@
// types, constants and helper functions of the linear adsr envelope block
// no dependencies
package ladsr_pkg;

  localparam int TimeBits = 32;
  localparam int FieldW   = 32;
  localparam int TimeW    = (TimeBits < FieldW) ? TimeBits : FieldW;
  localparam int CmpW     = (TimeW > 25) ? TimeW : 25;
  localparam int DurW     = 24;
  localparam int LvlW     = 16;
  localparam int NumW     = DurW + LvlW;
  localparam int DivSteps = LvlW;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 24;

  localparam logic [LvlW-1:0] LevelOne = 16'd32768;

  typedef enum logic [CfgIdxW-1:0] {
    RegAttack  = 3'd0,
    RegDecay   = 3'd1,
    RegRelease = 3'd2,
    RegStart   = 3'd3,
    RegSustain = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [LvlW-1:0] base;
    logic            neg;
    logic            held;
    logic            rel_done;
    logic [DurW-1:0] rel;
  } div_side_t;

  function automatic logic [DurW-1:0] dur_f(logic [DurW-1:0] v);
    return (v == '0) ? DurW'(1) : v;
  endfunction

  function automatic logic [LvlW-1:0] lvl_f(logic [LvlW-1:0] v);
    return (v > LevelOne) ? LevelOne : v;
  endfunction

endpackage

@@ src/ladsr_intf.sv @@
// valid/ready channel interfaces of the linear adsr envelope block
// depends on ladsr_pkg
interface ladsr_in_if;
  import ladsr_pkg::*;
  logic              valid;
  logic              ready;
  logic [FieldW-1:0] now_time;
  logic [FieldW-1:0] on_time;
  logic [FieldW-1:0] off_time;
  modport source (output valid, now_time, on_time, off_time, input ready);
  modport sink   (input valid, now_time, on_time, off_time, output ready);
endinterface

interface ladsr_out_if;
  import ladsr_pkg::*;
  logic            valid;
  logic            ready;
  logic [LvlW-1:0] level;
  logic            silent;
  modport source (output valid, level, silent, input ready);
  modport sink   (input valid, level, silent, output ready);
endinterface

interface ladsr_cfg_if;
  import ladsr_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ src/linear_adsr_envelope_top.sv @@
// linear adsr envelope: stages 1-3, a divider, stages 4-5, a divider and the output register;
// throughput one item per cycle while no result waits; the two 16-stage quotient pipelines set the depth
// the whole pipeline holds while a result waits at the output
// reset clears all valid bits and loads the default envelope registers
// depends on ladsr_pkg, ladsr_intf, ladsr_div and the assertion macro header
`include "linear_adsr_envelope_top_defines.svh"

module linear_adsr_envelope_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  ladsr_cfg_if.sink   cfg_i,
  ladsr_in_if.sink    in_i,
  ladsr_out_if.source out_o
);
  import ladsr_pkg::*;

  logic [DurW-1:0] attack_q, decay_q, release_q;
  logic [LvlW-1:0] start_q, sustain_q;

  logic [DurW-1:0] a_dur, d_dur, r_dur;
  logic [LvlW-1:0] s0, s1;

  logic            pipe_en;
  logic [4:0]      stage_v;

  // stage 1
  logic             p1_v_q, p1_held_q, p1_held_d;
  logic [TimeW-1:0] p1_x_q, p1_x_d, p1_rel_q, p1_rel_d;
  logic [TimeW-1:0] now_t, on_t, off_t;

  // stage 2
  logic             p2_v_q;
  logic [DurW-1:0]  p2_ma_q, p2_ma_d, p2_den_q, p2_den_d;
  logic [LvlW-1:0]  p2_mb_q, p2_mb_d;
  div_side_t        p2_side_q, p2_side_d;
  logic [CmpW-1:0]  x_ext, a_ext, ad_ext, rel_ext, rt_ext, t_full;

  // stage 3
  logic             p3_v_q;
  logic [NumW-1:0]  p3_num_q;
  logic [DurW-1:0]  p3_den_q;
  div_side_t        p3_side_q;

  // first divider
  logic             d1_v;
  logic [LvlW-1:0]  d1_quot;
  div_side_t        d1_side;

  // stage 4
  logic             p4_v_q;
  logic [LvlW-1:0]  p4_h_q, p4_h_d;
  div_side_t        p4_side_q;

  // stage 5
  logic             p5_v_q;
  logic [NumW-1:0]  p5_num_q;
  div_side_t        p5_side_q, p5_side_d;
  logic [DurW-1:0]  rel_mul;

  // second divider
  logic             d2_v;
  logic [LvlW-1:0]  d2_quot;
  div_side_t        d2_side;

  // output register
  logic             out_v_q;
  logic [LvlW-1:0]  out_level_q, out_level_d;
  logic             out_silent_q;

  // configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_q  <= 24'd4410;
      decay_q   <= 24'd4410;
      release_q <= 24'd8820;
      start_q   <= LevelOne;
      sustain_q <= LevelOne;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_reg_e'(cfg_i.index))
        RegAttack:  attack_q  <= cfg_i.data;
        RegDecay:   decay_q   <= cfg_i.data;
        RegRelease: release_q <= cfg_i.data;
        RegStart:   start_q   <= cfg_i.data[LvlW-1:0];
        RegSustain: sustain_q <= cfg_i.data[LvlW-1:0];
        default: ;
      endcase
    end
  end

  assign a_dur = dur_f(attack_q);
  assign d_dur = dur_f(decay_q);
  assign r_dur = dur_f(release_q);
  assign s0    = lvl_f(start_q);
  assign s1    = lvl_f(sustain_q);

  // global advance: the pipeline moves unless a result waits
  assign pipe_en    = !out_v_q || out_o.ready;
  assign in_i.ready = pipe_en;
  assign stage_v    = {p1_v_q, p2_v_q, p3_v_q, p4_v_q, p5_v_q};

  // stage 1: time differences
  assign now_t = in_i.now_time[TimeW-1:0];
  assign on_t  = in_i.on_time[TimeW-1:0];
  assign off_t = in_i.off_time[TimeW-1:0];

  always_comb begin
    p1_held_d = on_t > off_t;
    if (p1_held_d) begin
      p1_x_d = (now_t > on_t) ? (now_t - on_t) : '0;
    end else begin
      p1_x_d = off_t - on_t;
    end
    p1_rel_d = (now_t > off_t) ? (now_t - off_t) : '0;
  end

  // stage 2: segment select
  always_comb begin
    x_ext   = CmpW'(p1_x_q);
    a_ext   = CmpW'(a_dur);
    ad_ext  = CmpW'(a_dur) + CmpW'(d_dur);
    rel_ext = CmpW'(p1_rel_q);
    rt_ext  = CmpW'(r_dur);
    t_full  = x_ext - a_ext;

    p2_side_d.held     = p1_held_q;
    p2_side_d.rel_done = rel_ext >= rt_ext;
    p2_side_d.rel      = rel_ext[DurW-1:0];

    if (x_ext <= a_ext) begin
      p2_ma_d          = x_ext[DurW-1:0];
      p2_mb_d          = s0;
      p2_den_d         = a_dur;
      p2_side_d.base   = '0;
      p2_side_d.neg    = 1'b0;
    end else if (x_ext <= ad_ext) begin
      p2_ma_d          = t_full[DurW-1:0];
      p2_mb_d          = (s1 >= s0) ? (s1 - s0) : (s0 - s1);
      p2_den_d         = d_dur;
      p2_side_d.base   = s0;
      p2_side_d.neg    = s1 < s0;
    end else begin
      p2_ma_d          = '0;
      p2_mb_d          = '0;
      p2_den_d         = DurW'(1);
      p2_side_d.base   = s1;
      p2_side_d.neg    = 1'b0;
    end
  end

  // stage 4: held level
  assign p4_h_d = d1_side.neg ? (d1_side.base - d1_quot) : (d1_side.base + d1_quot);

  // stage 5: release product
  always_comb begin
    rel_mul            = (p4_side_q.held || p4_side_q.rel_done) ? '0 : p4_side_q.rel;
    p5_side_d          = p4_side_q;
    p5_side_d.base     = p4_h_q;
    p5_side_d.neg      = 1'b1;
  end

  // output level
  always_comb begin
    if (!d2_side.held && d2_side.rel_done) begin
      out_level_d = '0;
    end else begin
      out_level_d = d2_side.base - d2_quot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q  <= 1'b0;
      p2_v_q  <= 1'b0;
      p3_v_q  <= 1'b0;
      p4_v_q  <= 1'b0;
      p5_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (pipe_en) begin
      p1_v_q  <= in_i.valid;
      p2_v_q  <= p1_v_q;
      p3_v_q  <= p2_v_q;
      p4_v_q  <= d1_v;
      p5_v_q  <= p4_v_q;
      out_v_q <= d2_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      p1_held_q    <= p1_held_d;
      p1_x_q       <= p1_x_d;
      p1_rel_q     <= p1_rel_d;
      p2_ma_q      <= p2_ma_d;
      p2_mb_q      <= p2_mb_d;
      p2_den_q     <= p2_den_d;
      p2_side_q    <= p2_side_d;
      p3_num_q     <= NumW'(p2_ma_q) * NumW'(p2_mb_q);
      p3_den_q     <= p2_den_q;
      p3_side_q    <= p2_side_q;
      p4_h_q       <= p4_h_d;
      p4_side_q    <= d1_side;
      p5_num_q     <= NumW'(rel_mul) * NumW'(p4_h_q);
      p5_side_q    <= p5_side_d;
      out_level_q  <= out_level_d;
      out_silent_q <= out_level_d == '0;
    end
  end

  ladsr_div u_div_held (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (p3_v_q),
    .num_i   (p3_num_q),
    .den_i   (p3_den_q),
    .side_i  (p3_side_q),
    .valid_o (d1_v),
    .quot_o  (d1_quot),
    .side_o  (d1_side)
  );

  ladsr_div u_div_rel (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (p5_v_q),
    .num_i   (p5_num_q),
    .den_i   (r_dur),
    .side_i  (p5_side_q),
    .valid_o (d2_v),
    .quot_o  (d2_quot),
    .side_o  (d2_side)
  );

  assign out_o.valid  = out_v_q;
  assign out_o.level  = out_level_q;
  assign out_o.silent = out_silent_q;

  `LADSR_ASSERT_IMP(a_level_range, out_v_q, out_level_q <= LevelOne, "level above one")
  `LADSR_ASSERT_IMP(a_held_range, p4_v_q, p4_h_q <= LevelOne, "held level above one")
  `LADSR_ASSERT_NXT(a_stall_hold, !pipe_en, $stable(stage_v), "valid bits moved in stall")
  `LADSR_ASSERT_NXT(a_accept_enter, in_i.valid && in_i.ready, p1_v_q, "transfer lost")

endmodule

@@ src/ladsr_div.sv @@
// pipelined restoring divider, one quotient bit per stage
// depends on ladsr_pkg; quotient must fit in LvlW bits
module ladsr_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [ladsr_pkg::NumW-1:0]  num_i,
  input  logic [ladsr_pkg::DurW-1:0]  den_i,
  input  ladsr_pkg::div_side_t        side_i,
  output logic                        valid_o,
  output logic [ladsr_pkg::LvlW-1:0]  quot_o,
  output ladsr_pkg::div_side_t        side_o
);
  import ladsr_pkg::*;

  typedef struct packed {
    logic [DurW-1:0] rem;
    logic [LvlW-1:0] lo;
    logic [LvlW-1:0] quot;
    logic [DurW-1:0] den;
    div_side_t       side;
  } div_stage_t;

  function automatic div_stage_t step_f(div_stage_t cur);
    logic [DurW:0] trial;
    logic [DurW:0] diff;
    logic          ge;
    div_stage_t    nxt;
    trial    = {cur.rem, cur.lo[LvlW-1]};
    diff     = trial - {1'b0, cur.den};
    ge       = trial >= {1'b0, cur.den};
    nxt      = cur;
    nxt.rem  = ge ? diff[DurW-1:0] : trial[DurW-1:0];
    nxt.lo   = {cur.lo[LvlW-2:0], 1'b0};
    nxt.quot = {cur.quot[LvlW-2:0], ge};
    return nxt;
  endfunction

  div_stage_t           init;
  div_stage_t           st_d [DivSteps];
  div_stage_t           st_q [DivSteps];
  logic [DivSteps-1:0]  v_q;

  always_comb begin
    init.rem  = num_i[NumW-1:LvlW];
    init.lo   = num_i[LvlW-1:0];
    init.quot = '0;
    init.den  = den_i;
    init.side = side_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[DivSteps-2:0], valid_i};
    end
  end

  for (genvar k = 0; k < DivSteps; k++) begin : g_step
    if (k == 0) begin : g_first
      assign st_d[k] = step_f(init);
    end else begin : g_next
      assign st_d[k] = step_f(st_q[k-1]);
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  assign valid_o = v_q[DivSteps-1];
  assign quot_o  = st_q[DivSteps-1].quot;
  assign side_o  = st_q[DivSteps-1].side;

endmodule
